// ===== rtl/core/bba_pkg.sv =====
// shared constants, codes, types and helper functions of the bitmap block allocator
package bba_pkg;

  localparam int BLOCK_TOTAL = 4096;
  localparam int MAX_ALLOC  = 16;
  localparam int WORD_W     = 64;
  localparam int NUM_WORDS  = BLOCK_TOTAL / WORD_W;
  localparam int BIT_AW     = $clog2(WORD_W);
  localparam int WORD_AW    = $clog2(NUM_WORDS);
  localparam int IDX_W      = 12;
  localparam int CNT_W      = 5;
  localparam int CFG_W      = 13;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_RESET  = 4096;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_TEST  = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_ZERO    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FT,
    S_EMIT,
    S_SCAN_LD,
    S_SCAN_BIT,
    S_COMMIT_LD,
    S_COMMIT_BIT
  } state_t;

  // one result handed from the sequencer to the output register
  typedef struct packed {
    logic              vld;
    status_t           status;
    logic [IDX_W-1:0]  granted_block;
    logic              is_allocated;
    logic              last;
  } emit_t;

  // bitmap memory port request
  typedef struct packed {
    logic               rd_en;
    logic [WORD_AW-1:0] rd_addr;
    logic               wr_en;
    logic [WORD_AW-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
  } mem_req_t;

  // bits of word w that lie below the block limit
  function automatic logic [WORD_W-1:0] range_mask(input logic [WORD_AW:0] w,
                                                   input logic [CFG_W-1:0] lim);
    logic [WORD_AW:0]  hi;
    logic [BIT_AW-1:0] lo;
    hi = lim[CFG_W-1:BIT_AW];
    lo = lim[BIT_AW-1:0];
    if (w < hi) begin
      range_mask = '1;
    end else if (w == hi) begin
      range_mask = (WORD_W'(1) << lo) - WORD_W'(1);
    end else begin
      range_mask = '0;
    end
  endfunction

  // position of the lowest set bit
  function automatic logic [BIT_AW-1:0] lowest_pos(input logic [WORD_W-1:0] m);
    lowest_pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        lowest_pos = BIT_AW'(i);
      end
    end
  endfunction

endpackage

// ===== rtl/core/bba_if.sv =====
// request and result channel interfaces of the bitmap block allocator
interface bba_req_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] block_index;
  logic [CNT_W-1:0] alloc_count;

  modport source (output valid, op, block_index, alloc_count, input ready);
  modport sink   (input valid, op, block_index, alloc_count, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  granted_block;
  logic              is_allocated;
  logic              last;

  modport source (output valid, status, granted_block, is_allocated, last, input ready);
  modport sink   (input valid, status, granted_block, is_allocated, last, output ready);
endinterface

// ===== rtl/core/bba_ram.sv =====
// generic single-write, single-read ram with registered read data
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/bba_out_reg.sv =====
// result output register between the sequencer and the result channel
module bba_out_reg import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  emit_t       emit,
  output logic        slot_free,
  bba_rsp_if.source   out_if
);

  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic [IDX_W-1:0]  block_r;
  logic              is_alloc_r;
  logic              last_r;

  assign slot_free = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.vld) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.vld) begin
      status_r   <= emit.status;
      block_r    <= emit.granted_block;
      is_alloc_r <= emit.is_allocated;
      last_r     <= emit.last;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = status_r;
  assign out_if.granted_block = block_r;
  assign out_if.is_allocated  = is_alloc_r;
  assign out_if.last          = last_r;

endmodule

// ===== rtl/core/bba_ctrl.sv =====
// request sequencer: decode, two-pass first-fit scan and read-modify-write of the bitmap
module bba_ctrl import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CFG_W-1:0]  lim,
  bba_req_if.sink           in_if,
  output mem_req_t          mem,
  input  logic [WORD_W-1:0] mem_rd_data,
  input  logic              slot_free,
  output emit_t             emit
);

  state_t             state_r, state_nxt;
  logic [WORD_AW-1:0] word_r, word_nxt;
  logic [CNT_W-1:0]   found_r, found_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WORD_W-1:0]  mask_r, mask_nxt;
  logic [WORD_W-1:0]  take_r, take_nxt;
  logic [WORD_W-1:0]  data_r, data_nxt;
  logic [BIT_AW-1:0]  bitsel_r, bitsel_nxt;
  op_t                op_r, op_nxt;
  status_t            stat_r, stat_nxt;
  logic               isal_r, isal_nxt;
  logic [NUM_WORDS-1:0] row_vld_r;
  logic               rd_vld_r;

  logic [WORD_W-1:0]  rdata;
  logic [WORD_W-1:0]  low_bit;
  logic [BIT_AW-1:0]  low_pos;
  logic [WORD_AW:0]   next_w;
  logic               idx_ok;

  // rows never written read as all free
  assign rdata   = rd_vld_r ? mem_rd_data : '0;
  assign low_bit = mask_r & (~mask_r + WORD_W'(1));
  assign low_pos = lowest_pos(mask_r);
  assign next_w  = {1'b0, word_r} + 1'b1;
  assign idx_ok  = {1'b0, in_if.block_index} < lim;

  assign in_if.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    word_nxt   = word_r;
    found_nxt  = found_r;
    cnt_nxt    = cnt_r;
    mask_nxt   = mask_r;
    take_nxt   = take_r;
    data_nxt   = data_r;
    bitsel_nxt = bitsel_r;
    op_nxt     = op_r;
    stat_nxt   = stat_r;
    isal_nxt   = isal_r;
    mem        = '0;
    emit       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          isal_nxt = 1'b0;
          unique case (in_if.op) inside
            OP_ALLOC: begin
              if (in_if.alloc_count == '0) begin
                stat_nxt  = STAT_ZERO;
                state_nxt = S_EMIT;
              end else if (in_if.alloc_count > CNT_W'(MAX_ALLOC) || lim == '0) begin
                stat_nxt  = STAT_NOSPACE;
                state_nxt = S_EMIT;
              end else begin
                cnt_nxt     = in_if.alloc_count;
                found_nxt   = '0;
                word_nxt    = '0;
                mem.rd_en   = 1'b1;
                mem.rd_addr = '0;
                state_nxt   = S_SCAN_LD;
              end
            end
            OP_FREE, OP_TEST: begin
              if (idx_ok) begin
                op_nxt      = op_t'(in_if.op);
                word_nxt    = in_if.block_index[IDX_W-1:BIT_AW];
                bitsel_nxt  = in_if.block_index[BIT_AW-1:0];
                mem.rd_en   = 1'b1;
                mem.rd_addr = in_if.block_index[IDX_W-1:BIT_AW];
                state_nxt   = S_FT;
              end else begin
                stat_nxt  = STAT_RANGE;
                state_nxt = S_EMIT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_FT: begin
        stat_nxt  = STAT_OK;
        state_nxt = S_EMIT;
        if (op_r == OP_FREE) begin
          mem.wr_en   = 1'b1;
          mem.wr_addr = word_r;
          mem.wr_data = rdata & ~(WORD_W'(1) << bitsel_r);
        end else begin
          isal_nxt = rdata[bitsel_r];
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          emit.vld          = 1'b1;
          emit.status       = stat_r;
          emit.is_allocated = isal_r;
          emit.last         = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      // first pass: count free blocks, nothing written
      S_SCAN_LD: begin
        mask_nxt  = ~rdata & range_mask({1'b0, word_r}, lim);
        state_nxt = S_SCAN_BIT;
      end

      S_SCAN_BIT: begin
        if (found_r == cnt_r) begin
          found_nxt   = '0;
          word_nxt    = '0;
          mem.rd_en   = 1'b1;
          mem.rd_addr = '0;
          state_nxt   = S_COMMIT_LD;
        end else if (mask_r == '0) begin
          if (range_mask(next_w, lim) != '0) begin
            word_nxt    = next_w[WORD_AW-1:0];
            mem.rd_en   = 1'b1;
            mem.rd_addr = next_w[WORD_AW-1:0];
            state_nxt   = S_SCAN_LD;
          end else begin
            stat_nxt  = STAT_NOSPACE;
            state_nxt = S_EMIT;
          end
        end else begin
          found_nxt = found_r + 1'b1;
          mask_nxt  = mask_r & (mask_r - WORD_W'(1));
        end
      end

      // second pass: same walk, grant each block and write each word back
      S_COMMIT_LD: begin
        mask_nxt  = ~rdata & range_mask({1'b0, word_r}, lim);
        data_nxt  = rdata;
        take_nxt  = '0;
        state_nxt = S_COMMIT_BIT;
      end

      S_COMMIT_BIT: begin
        if (mask_r == '0) begin
          mem.wr_en   = 1'b1;
          mem.wr_addr = word_r;
          mem.wr_data = data_r | take_r;
          word_nxt    = next_w[WORD_AW-1:0];
          mem.rd_en   = 1'b1;
          mem.rd_addr = next_w[WORD_AW-1:0];
          state_nxt   = S_COMMIT_LD;
        end else if (slot_free) begin
          emit.vld           = 1'b1;
          emit.status        = STAT_OK;
          emit.granted_block = {word_r, low_pos};
          emit.last          = (CNT_W'(found_r + 1'b1) == cnt_r);
          found_nxt          = found_r + 1'b1;
          take_nxt           = take_r | low_bit;
          mask_nxt           = mask_r & (mask_r - WORD_W'(1));
          if (CNT_W'(found_r + 1'b1) == cnt_r) begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = word_r;
            mem.wr_data = data_r | take_r | low_bit;
            state_nxt   = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      row_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (mem.wr_en) begin
        row_vld_r[mem.wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    found_r  <= found_nxt;
    cnt_r    <= cnt_nxt;
    mask_r   <= mask_nxt;
    take_r   <= take_nxt;
    data_r   <= data_nxt;
    bitsel_r <= bitsel_nxt;
    op_r     <= op_nxt;
    stat_r   <= stat_nxt;
    isal_r   <= isal_nxt;
    if (mem.rd_en) begin
      rd_vld_r <= row_vld_r[mem.rd_addr];
    end
  end

`ifndef ASSERT_OFF
  a_emit_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit.vld |-> slot_free)
    else $error("result issued while output register is full");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem.rd_en && mem.wr_en) |-> (mem.rd_addr != mem.wr_addr))
    else $error("read and write of the same bitmap word in one cycle");

  a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.vld && emit.last) |=> (state_r == S_IDLE))
    else $error("sequencer busy after final result of a request");

  a_grant_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT_BIT || state_r == S_SCAN_BIT) |-> (found_r <= cnt_r))
    else $error("more blocks counted than requested");
`endif

endmodule

// ===== rtl/core/bitmap_block_allocator_core.sv =====
// top level of the bitmap first-fit block allocator
// One used bit per block, 64 bits to a word, in a 64-word synchronous ram; a
// row that was never written reads as all free (per-row valid flops cleared by
// reset), so the block is usable right after reset with no clearing pass.
// Free and test read the word on accept, then clear or sample the bit, then
// hand over the result. Allocate walks the words twice through the single read
// port: a counting pass, then, only if enough blocks are free, a granting pass
// that writes each touched word back and emits one result per block in rising
// index order with last on the final one. A failing request makes only the
// counting pass, over the active words. Output stalls hold the granting pass.
// cfg writes set the number of active blocks, capped at 4096; blocks at or above
// it are invisible but keep their bits.
module bitmap_block_allocator_core import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  bba_req_if.sink          in_if,
  bba_rsp_if.source        out_if
);

  logic [CFG_W-1:0]  active_blocks_r;
  logic [CFG_W-1:0]  lim;
  mem_req_t          mem;
  logic [WORD_W-1:0] mem_rd_data;
  logic              slot_free;
  emit_t             emit;

  // active block count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_blocks_r <= CFG_W'(CFG_RESET);
    end else if (cfg_wr_en) begin
      active_blocks_r <= cfg_wr_data;
    end
  end

  // effective limit, never above the bitmap size
  assign lim = (active_blocks_r > CFG_W'(BLOCK_TOTAL)) ? CFG_W'(BLOCK_TOTAL) : active_blocks_r;

  // request sequencer
  bba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .lim         (lim),
    .in_if       (in_if),
    .mem         (mem),
    .mem_rd_data (mem_rd_data),
    .slot_free   (slot_free),
    .emit        (emit)
  );

  // used bitmap storage
  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk     (clk),
    .rd_en   (mem.rd_en),
    .rd_addr (mem.rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem.wr_en),
    .wr_addr (mem.wr_addr),
    .wr_data (mem.wr_data)
  );

  // result register, lets the sequencer go on while a result waits
  bba_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .slot_free (slot_free),
    .out_if    (out_if)
  );

endmodule

// ===== sim/tb_bitmap_block_allocator_core.sv =====
// self-checking testbench of the bitmap first-fit block allocator core
module tb_bitmap_block_allocator_core import bba_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // op code that the block takes but answers with nothing
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // worst allocate is two passes over all 64 words plus 16 grants
  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_GAP       = 13;
  localparam int PHASE_ITEMS   = 32;

  // one reply item as the allocator should produce it
  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] granted_block;
    logic             is_allocated;
    logic             last;
  } reply_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  bitmap_block_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_if      (req_ch),
    .out_if     (rsp_ch)
  );

  // shadow of the allocator: used bit per block and the block-count register
  logic [BLOCK_TOTAL-1:0] shadow_used;
  logic [CFG_W-1:0]       shadow_active;
  reply_t                 expected_replies[$];
  int                     mismatches;
  // stretches of back-to-back traffic on either side
  bit                     send_steady;
  bit                     sink_steady;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // blocks at or above the register value are out of range, capped at the array size
  function automatic int unsigned managed_blocks();
    return (shadow_active > BLOCK_TOTAL) ? BLOCK_TOTAL : int'(shadow_active);
  endfunction

  function automatic int unsigned free_blocks_in_range();
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < managed_blocks(); i++) begin
      if (!shadow_used[i]) begin
        n++;
      end
    end
    return n;
  endfunction

  function automatic void queue_reply(status_t st, logic [IDX_W-1:0] blk, logic alloc,
                                      logic last);
    reply_t r;
    r.status        = st;
    r.granted_block = blk;
    r.is_allocated  = alloc;
    r.last          = last;
    expected_replies.push_back(r);
  endfunction

  // predict the replies of one accepted request item and update the shadow bitmap
  function automatic void apply_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                        logic [CNT_W-1:0] cnt);
    int unsigned lim;
    int unsigned picked[$];
    lim = managed_blocks();
    case (op)
      OP_ALLOC: begin
        if (cnt == 0) begin
          queue_reply(STAT_ZERO, '0, 1'b0, 1'b1);
        end else if (cnt > MAX_ALLOC) begin
          // can never be granted
          queue_reply(STAT_NOSPACE, '0, 1'b0, 1'b1);
        end else begin
          // first fit: lowest free blocks in range, all or none
          for (int unsigned i = 0; i < lim && picked.size() < cnt; i++) begin
            if (!shadow_used[i]) begin
              picked.push_back(i);
            end
          end
          if (picked.size() < cnt) begin
            queue_reply(STAT_NOSPACE, '0, 1'b0, 1'b1);
          end else begin
            foreach (picked[k]) begin
              shadow_used[picked[k]] = 1'b1;
              queue_reply(STAT_OK, IDX_W'(picked[k]), 1'b0, k == picked.size() - 1);
            end
          end
        end
      end
      OP_FREE: begin
        if (idx >= lim) begin
          queue_reply(STAT_RANGE, '0, 1'b0, 1'b1);
        end else begin
          shadow_used[idx] = 1'b0;
          queue_reply(STAT_OK, '0, 1'b0, 1'b1);
        end
      end
      OP_TEST: begin
        if (idx >= lim) begin
          queue_reply(STAT_RANGE, '0, 1'b0, 1'b1);
        end else begin
          queue_reply(STAT_OK, '0, shadow_used[idx], 1'b1);
        end
      end
      default: begin
        // unknown op: no reply, no change
      end
    endcase
  endfunction

  // present one request item after a random gap and hold it until accepted;
  // valid stays high afterwards so a following item with no gap goes back to back
  task automatic send_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                              logic [CNT_W-1:0] cnt);
    int gap;
    if ($urandom_range(0, 24) == 0) begin
      send_steady = !send_steady;
    end
    gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.block_index <= idx;
    req_ch.alloc_count <= cnt;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    apply_request(op, idx, cnt);
  endtask

  // drop valid, wait for every predicted reply, then let trailing work finish
  task automatic wait_until_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write only with the block idle
  task automatic set_active_blocks(logic [CFG_W-1:0] value);
    wait_until_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_active = value;
  endtask

  // random request mix; indices mostly in range, the rest anywhere
  task automatic send_random_request();
    int unsigned      sel;
    int unsigned      lim;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    sel = $urandom_range(0, 99);
    lim = managed_blocks();
    idx = IDX_W'($urandom());
    cnt = CNT_W'($urandom());
    if (lim > 0 && $urandom_range(0, 5) != 0) begin
      idx = IDX_W'($urandom_range(0, lim - 1));
    end
    if (sel < 50) begin
      op = OP_ALLOC;
      case ($urandom_range(0, 19))
        0:       cnt = '0;
        1:       cnt = CNT_W'($urandom_range(MAX_ALLOC + 1, 31));
        default: cnt = CNT_W'($urandom_range(1, MAX_ALLOC));
      endcase
    end else if (sel < 75) begin
      op = OP_FREE;
    end else if (sel < 95) begin
      op = OP_TEST;
    end else begin
      op = OP_UNUSED;
    end
    send_request(op, idx, cnt);
  endtask

  // fresh map: every block free, freeing a free block is fine
  task automatic test_reset_state();
    send_request(OP_TEST, '0, '0);
    send_request(OP_TEST, '1, '1);
    send_request(OP_FREE, IDX_W'(5), '0);
  endtask

  // zero count, counts past the limit, first fit across holes, unknown op
  task automatic test_alloc_requests();
    send_request(OP_ALLOC, '1, '0);
    send_request(OP_ALLOC, '0, CNT_W'(MAX_ALLOC + 1));
    send_request(OP_ALLOC, '0, '1);
    send_request(OP_ALLOC, '0, CNT_W'(1));
    send_request(OP_ALLOC, '1, CNT_W'(MAX_ALLOC));
    send_request(OP_TEST, IDX_W'(16), '0);
    send_request(OP_FREE, IDX_W'(3), '0);
    send_request(OP_ALLOC, '0, CNT_W'(2));
    send_request(OP_UNUSED, '1, '1);
    send_request(OP_FREE, '1, '0);
    send_request(OP_TEST, '1, '0);
  endtask

  // register extremes: one block, no block, all ones (capped at the array size)
  task automatic test_active_range();
    set_active_blocks(CFG_W'(1));
    send_request(OP_ALLOC, '0, CNT_W'(2));
    send_request(OP_TEST, IDX_W'(1), '0);
    send_request(OP_FREE, IDX_W'(1), '0);
    send_request(OP_FREE, '0, '0);
    send_request(OP_ALLOC, '0, CNT_W'(1));
    send_request(OP_TEST, '0, '0);
    set_active_blocks('0);
    send_request(OP_ALLOC, '0, CNT_W'(1));
    send_request(OP_TEST, '0, '0);
    set_active_blocks('1);
    send_request(OP_TEST, '1, '0);
    send_request(OP_FREE, '1, '0);
  endtask

  // grant blocks until the whole map is used, then run out of space
  task automatic test_fill_map();
    int unsigned left;
    set_active_blocks(CFG_W'(CFG_RESET));
    while (free_blocks_in_range() >= MAX_ALLOC) begin
      send_request(OP_ALLOC, IDX_W'($urandom()), CNT_W'(MAX_ALLOC));
    end
    send_request(OP_ALLOC, IDX_W'($urandom()), CNT_W'(MAX_ALLOC));
    left = free_blocks_in_range();
    if (left > 0) begin
      send_request(OP_ALLOC, IDX_W'($urandom()), CNT_W'(left));
    end
    send_request(OP_ALLOC, IDX_W'($urandom()), CNT_W'(1));
  endtask

  // mixed traffic under several block counts; bits beyond a small range persist
  task automatic test_random_traffic();
    logic [CFG_W-1:0] setting;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       setting = CFG_W'(CFG_RESET);
        1:       setting = CFG_W'($urandom_range(1, 64));
        2:       setting = '1;
        3:       setting = CFG_W'($urandom_range(1, BLOCK_TOTAL));
        4:       setting = CFG_W'(BLOCK_TOTAL + 1);
        default: setting = CFG_W'($urandom_range(65, BLOCK_TOTAL - 1));
      endcase
      set_active_blocks(setting);
      repeat (PHASE_ITEMS) send_random_request();
    end
  endtask

  // reply side: random stalls, each accepted item checked against the oldest prediction
  initial begin : reply_checker
    reply_t want;
    int     stall;
    rsp_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 24) == 0) begin
        sink_steady = !sink_steady;
      end
      stall = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      if (expected_replies.size() == 0) begin
        $error("reply item with none expected: status %0d block %0d", rsp_ch.status,
               rsp_ch.granted_block);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.granted_block !== want.granted_block) begin
          $error("granted_block: expected %0d, got %0d", want.granted_block,
                 rsp_ch.granted_block);
          mismatches++;
        end
        if (rsp_ch.is_allocated !== want.is_allocated) begin
          $error("is_allocated: expected %0d, got %0d", want.is_allocated,
                 rsp_ch.is_allocated);
          mismatches++;
        end
        if (rsp_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    req_ch.valid       <= 1'b0;
    req_ch.op          <= OP_ALLOC;
    req_ch.block_index <= '0;
    req_ch.alloc_count <= '0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    rst_n              <= 1'b0;
    shadow_used   = '0;
    shadow_active = CFG_W'(CFG_RESET);
    mismatches    = 0;
    send_steady   = 1'b0;
    sink_steady   = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_alloc_requests();
    test_active_range();
    test_fill_map();
    test_random_traffic();

    wait_until_drained();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== bitmap_block_allocator_core.f =====
rtl/core/bba_pkg.sv
rtl/core/bba_if.sv
rtl/core/bba_ram.sv
rtl/core/bba_out_reg.sv
rtl/core/bba_ctrl.sv
rtl/core/bitmap_block_allocator_core.sv
sim/tb_bitmap_block_allocator_core.sv
